FILE: design/hsvrgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Constants for the hsv to rgb converter: hue sector span, fixed point unit
// levels, reciprocal multipliers and the sector routing codes.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int HueWidth   = 17;
   localparam int LevelWidth = 8;

   // one sector is 60 degrees of 256 hue steps, 15 * 1024
   localparam int SectorCoarse = 15;
   localparam int SectorSpan   = 15360;
   localparam int SectorCount  = 8;
   localparam int RemWidth     = 14;
   localparam int SectorWidth  = 4;

   localparam int UnitLevel = 255;
   localparam int FullScale = UnitLevel * SectorSpan;   // 3916800
   localparam int ScaleWidth = 22;

   // floor(x / 255) for 16-bit x is (x * 0x8081) >> 23
   localparam logic [15:0] RecipLevel = 16'h8081;
   localparam int RecipLevelShift = 23;

   // floor(x / 3825) for x below 2^20 is (x * ceil(2^32 / 3825)) >> 32
   localparam logic [20:0] RecipScale = 21'd1122868;
   localparam int RecipScaleShift = 32;
   localparam int ScaledWidth = 20;

   localparam logic [SectorWidth-1:0] SectorRedToYellow    = 4'd0;
   localparam logic [SectorWidth-1:0] SectorYellowToGreen  = 4'd1;
   localparam logic [SectorWidth-1:0] SectorGreenToCyan    = 4'd2;
   localparam logic [SectorWidth-1:0] SectorCyanToBlue     = 4'd3;
   localparam logic [SectorWidth-1:0] SectorBlueToMagenta  = 4'd4;

endpackage
`default_nettype wire

FILE: design/hsv_to_rgb_converter_unit.sv
`default_nettype none
// A beat taken at one edge moves through the stage registers s1 to s6 and
// shows its rsp_valid strobe when it reaches s6.
// Throughput: one color per clock; busy is held low, a new beat may come
// every cycle since every stage advances each clock.
// Reset: synchronous, clears the valid bit of each stage; data is not reset.
// The receiver cannot stall, results show for one cycle only.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Six stage pipeline that turns hue, saturation and value into red, green
// and blue levels using fixed point reciprocal scaling.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [hsvrgb_pkg::HueWidth-1:0]    req_hue,
   input  wire logic [hsvrgb_pkg::LevelWidth-1:0]  req_saturation,
   input  wire logic [hsvrgb_pkg::LevelWidth-1:0]  req_brightness,
   output logic                                    rsp_valid,
   output logic [hsvrgb_pkg::LevelWidth-1:0]       rsp_red,
   output logic [hsvrgb_pkg::LevelWidth-1:0]       rsp_green,
   output logic [hsvrgb_pkg::LevelWidth-1:0]       rsp_blue
);
   import hsvrgb_pkg::*;

   // stage 1: sector and remainder
   logic                    s1_valid_ff, s1_valid_in;
   logic [SectorWidth-1:0]  s1_sector_ff, s1_sector_in;
   logic [RemWidth-1:0]     s1_rem_ff, s1_rem_in;
   logic [LevelWidth-1:0]   s1_sat_ff, s1_val_ff;

   // stage 2: saturation products
   logic                    s2_valid_ff;
   logic [SectorWidth-1:0]  s2_sector_ff;
   logic [LevelWidth-1:0]   s2_val_ff;
   logic [ScaleWidth-1:0]   s2_srq_ff, s2_srq_in, s2_srt_ff, s2_srt_in;
   logic [15:0]             s2_pprod_ff, s2_pprod_in;

   // stage 3: scale numerators and p
   logic                    s3_valid_ff;
   logic [SectorWidth-1:0]  s3_sector_ff;
   logic [LevelWidth-1:0]   s3_val_ff;
   logic [ScaleWidth-1:0]   s3_nq_ff, s3_nq_in, s3_nt_ff, s3_nt_in;
   logic [LevelWidth-1:0]   s3_p_ff, s3_p_in;
   logic [31:0]             p_recip;

   // stage 4: value times numerator, pre-divided by 1024
   logic                    s4_valid_ff;
   logic [SectorWidth-1:0]  s4_sector_ff;
   logic [LevelWidth-1:0]   s4_val_ff, s4_p_ff;
   logic [ScaledWidth-1:0]  s4_xq_ff, s4_xq_in, s4_xt_ff, s4_xt_in;
   logic [29:0]             q_prod, t_prod;

   // stage 5: divide by 3825
   logic                    s5_valid_ff;
   logic [SectorWidth-1:0]  s5_sector_ff;
   logic [LevelWidth-1:0]   s5_val_ff, s5_p_ff;
   logic [LevelWidth-1:0]   s5_q_ff, s5_q_in, s5_t_ff, s5_t_in;
   logic [40:0]             q_recip, t_recip;

   // stage 6: routed outputs
   logic                    s6_valid_ff;
   logic [LevelWidth-1:0]   s6_red_ff, s6_red_in;
   logic [LevelWidth-1:0]   s6_green_ff, s6_green_in;
   logic [LevelWidth-1:0]   s6_blue_ff, s6_blue_in;

   logic [6:0]              hue_coarse;
   logic [3:0]              coarse_rem;
   logic [RemWidth-1:0]     rem_comp;

   assign busy = 1'b0;

   always_comb begin
      s1_valid_in = start & ~busy;
      hue_coarse  = req_hue[HueWidth-1:10];
      s1_sector_in = '0;
      for (int k = 1; k <= SectorCount; k++) begin
         if (hue_coarse >= 7'(k * SectorCoarse)) begin
            s1_sector_in = SectorWidth'(k);
         end
      end
      coarse_rem = 4'(hue_coarse - 7'(s1_sector_in) * 7'(SectorCoarse));
      s1_rem_in  = {coarse_rem, req_hue[9:0]};
   end

   always_comb begin
      rem_comp    = RemWidth'(SectorSpan) - s1_rem_ff;
      s2_srq_in   = ScaleWidth'(s1_sat_ff) * ScaleWidth'(s1_rem_ff);
      s2_srt_in   = ScaleWidth'(s1_sat_ff) * ScaleWidth'(rem_comp);
      s2_pprod_in = 16'(s1_val_ff) * 16'(8'(UnitLevel) - s1_sat_ff);
   end

   // zero saturation makes p, q and t equal to v, so grey needs no bypass
   always_comb begin
      s3_nq_in = ScaleWidth'(FullScale) - s2_srq_ff;
      s3_nt_in = ScaleWidth'(FullScale) - s2_srt_ff;
      p_recip  = s2_pprod_ff * RecipLevel;
      s3_p_in  = p_recip[RecipLevelShift+LevelWidth-1:RecipLevelShift];
   end

   always_comb begin
      q_prod   = s3_val_ff * s3_nq_ff;
      t_prod   = s3_val_ff * s3_nt_ff;
      s4_xq_in = q_prod[29:10];
      s4_xt_in = t_prod[29:10];
   end

   always_comb begin
      q_recip = s4_xq_ff * RecipScale;
      t_recip = s4_xt_ff * RecipScale;
      s5_q_in = q_recip[RecipScaleShift+LevelWidth-1:RecipScaleShift];
      s5_t_in = t_recip[RecipScaleShift+LevelWidth-1:RecipScaleShift];
   end

   always_comb begin
      unique case (s5_sector_ff)
         SectorRedToYellow: begin
            s6_red_in = s5_val_ff; s6_green_in = s5_t_ff; s6_blue_in = s5_p_ff;
         end
         SectorYellowToGreen: begin
            s6_red_in = s5_q_ff; s6_green_in = s5_val_ff; s6_blue_in = s5_p_ff;
         end
         SectorGreenToCyan: begin
            s6_red_in = s5_p_ff; s6_green_in = s5_val_ff; s6_blue_in = s5_t_ff;
         end
         SectorCyanToBlue: begin
            s6_red_in = s5_p_ff; s6_green_in = s5_q_ff; s6_blue_in = s5_val_ff;
         end
         SectorBlueToMagenta: begin
            s6_red_in = s5_t_ff; s6_green_in = s5_p_ff; s6_blue_in = s5_val_ff;
         end
         // last sector, and hues beyond 360 degrees
         default: begin
            s6_red_in = s5_val_ff; s6_green_in = s5_p_ff; s6_blue_in = s5_q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_rem_ff    <= s1_rem_in;
      s1_sat_ff    <= req_saturation;
      s1_val_ff    <= req_brightness;

      s2_sector_ff <= s1_sector_ff;
      s2_val_ff    <= s1_val_ff;
      s2_srq_ff    <= s2_srq_in;
      s2_srt_ff    <= s2_srt_in;
      s2_pprod_ff  <= s2_pprod_in;

      s3_sector_ff <= s2_sector_ff;
      s3_val_ff    <= s2_val_ff;
      s3_nq_ff     <= s3_nq_in;
      s3_nt_ff     <= s3_nt_in;
      s3_p_ff      <= s3_p_in;

      s4_sector_ff <= s3_sector_ff;
      s4_val_ff    <= s3_val_ff;
      s4_p_ff      <= s3_p_ff;
      s4_xq_ff     <= s4_xq_in;
      s4_xt_ff     <= s4_xt_in;

      s5_sector_ff <= s4_sector_ff;
      s5_val_ff    <= s4_val_ff;
      s5_p_ff      <= s4_p_ff;
      s5_q_ff      <= s5_q_in;
      s5_t_ff      <= s5_t_in;

      s6_red_ff    <= s6_red_in;
      s6_green_ff  <= s6_green_in;
      s6_blue_ff   <= s6_blue_in;
   end

   assign rsp_valid = s6_valid_ff;
   assign rsp_red   = s6_red_ff;
   assign rsp_green = s6_green_ff;
   assign rsp_blue  = s6_blue_ff;

endmodule
`default_nettype wire
